// ===== sv/mrtu_pkg.sv =====
// ----------------------------------------------------------------------------
// mrtu_pkg: shared types, constants and CRC helper
// Phase codes, register indexes, result layout and the CRC-16 byte update
// used by the request receiver.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  // Default frame geometry
  localparam int FRAME_LIMIT_DEF = 20;
  localparam int DATA_MAX_DEF    = 10;

  // Configuration register indexes
  localparam logic REG_DEVICE_ID = 1'b0;
  localparam logic REG_GAP_LIMIT = 1'b1;

  // Configuration reset values
  localparam logic [6:0] DEVICE_ID_RST = 7'd1;
  localparam logic [7:0] GAP_LIMIT_RST = 8'd100;

  // CRC-16 parameters (reflected polynomial)
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Function codes
  localparam logic [7:0] FC_READ_COILS  = 8'd1;
  localparam logic [7:0] FC_READ_HOLD   = 8'd3;
  localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
  localparam logic [7:0] FC_WRITE_REG   = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS = 8'd15;

  // Number of data bytes visible on the outputs
  localparam int COIL_BYTES = 10;

  // Parser phases
  localparam logic [3:0] PH_ADDR = 4'd0;
  localparam logic [3:0] PH_FUNC = 4'd1;
  localparam logic [3:0] PH_AHI  = 4'd2;
  localparam logic [3:0] PH_ALO  = 4'd3;
  localparam logic [3:0] PH_VHI  = 4'd4;
  localparam logic [3:0] PH_VLO  = 4'd5;
  localparam logic [3:0] PH_CLO  = 4'd6;
  localparam logic [3:0] PH_CHI  = 4'd7;
  localparam logic [3:0] PH_BCNT = 4'd8;
  localparam logic [3:0] PH_DATA = 4'd9;

  typedef struct packed {
    logic [6:0] device_id;
    logic [7:0] gap_limit_ms;
  } cfg_t;

  // Decoded request, last field in the lowest bits
  typedef struct packed {
    logic [15:0] coil_bits_high;
    logic [63:0] coil_bits_low;
    logic [3:0]  data_length;
    logic [15:0] count_or_value;
    logic [15:0] first_address;
    logic [3:0]  func_code;
  } res_t;

  // Fold one byte into the running CRC, one bit per step
  function automatic logic [15:0] mrtu_crc_byte(input logic [15:0] crc_in,
                                                input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ===== sv/mrtu_parser.sv =====
// ----------------------------------------------------------------------------
// mrtu_parser: byte-wise frame parser
// Tracks the frame phase, running CRC and held fields; flags a decoded
// request in the cycle the last CRC byte is stepped in.
// ----------------------------------------------------------------------------
module mrtu_parser #(
  parameter int FRAME_LIMIT = mrtu_pkg::FRAME_LIMIT_DEF,
  parameter int DATA_MAX    = mrtu_pkg::DATA_MAX_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mrtu_pkg::cfg_t  cfg_i,
  input  logic            step_i,
  input  logic [7:0]      rx_byte_i,
  input  logic [7:0]      gap_ms_i,
  output logic            hit_o,
  output mrtu_pkg::res_t  res_o
);
  import mrtu_pkg::*;

  localparam int FB_W    = $clog2(FRAME_LIMIT + 1);
  localparam int FILL_W  = $clog2(DATA_MAX + 1);
  localparam int STORE_D = (DATA_MAX < COIL_BYTES) ? DATA_MAX : COIL_BYTES;

  logic [3:0]        phase_q, phase_d, phase_v;
  logic [FB_W-1:0]   fbytes_q, fbytes_d, fbytes_v;
  logic [15:0]       crc_q, crc_d, crc_upd;
  logic [3:0]        func_q, func_d;
  logic [15:0]       addr_q, addr_d;
  logic [15:0]       value_q, value_d;
  logic [FILL_W-1:0] decl_q, decl_d;
  logic [FILL_W-1:0] fill_q, fill_d, fill_inc;
  logic [7:0]        fcrc_lo_q, fcrc_lo_d;
  logic              store_we;
  logic [7:0]        store_q [STORE_D];
  logic [7:0]        coil_byte [COIL_BYTES];

  assign crc_upd  = mrtu_crc_byte(crc_q, rx_byte_i);
  assign fill_inc = fill_q + FILL_W'(1);

  // Next-state logic for one received byte
  always_comb begin
    phase_d   = phase_q;
    fbytes_d  = fbytes_q;
    crc_d     = crc_q;
    func_d    = func_q;
    addr_d    = addr_q;
    value_d   = value_q;
    decl_d    = decl_q;
    fill_d    = fill_q;
    fcrc_lo_d = fcrc_lo_q;
    phase_v   = phase_q;
    fbytes_v  = fbytes_q;
    store_we  = 1'b0;
    hit_o     = 1'b0;

    // Drop back to address hunt on a long idle gap
    if (gap_ms_i > cfg_i.gap_limit_ms) begin
      phase_v  = PH_ADDR;
      fbytes_v = '0;
    end

    // Count frame bytes and abort an overlong frame
    if (phase_v != PH_ADDR) begin
      fbytes_v = fbytes_v + FB_W'(1);
      if (fbytes_v >= FB_W'(FRAME_LIMIT)) begin
        phase_v  = PH_ADDR;
        fbytes_v = '0;
      end
    end

    phase_d  = phase_v;
    fbytes_d = fbytes_v;

    case (phase_v)
      PH_ADDR: begin
        if (rx_byte_i == {1'b0, cfg_i.device_id}) begin
          crc_d     = mrtu_crc_byte(CRC_INIT, rx_byte_i);
          fbytes_d  = FB_W'(1);
          func_d    = '0;
          addr_d    = '0;
          value_d   = '0;
          decl_d    = '0;
          fill_d    = '0;
          fcrc_lo_d = '0;
          phase_d   = PH_FUNC;
        end
      end
      PH_FUNC: begin
        crc_d  = crc_upd;
        func_d = rx_byte_i[3:0];
        if (rx_byte_i == FC_READ_COILS || rx_byte_i == FC_READ_HOLD ||
            rx_byte_i == FC_WRITE_COIL || rx_byte_i == FC_WRITE_REG ||
            rx_byte_i == FC_WRITE_COILS) begin
          phase_d = PH_AHI;
        end else begin
          phase_d = PH_ADDR;
        end
      end
      PH_AHI: begin
        crc_d   = crc_upd;
        addr_d  = {rx_byte_i, addr_q[7:0]};
        phase_d = PH_ALO;
      end
      PH_ALO: begin
        crc_d   = crc_upd;
        addr_d  = {addr_q[15:8], rx_byte_i};
        phase_d = PH_VHI;
      end
      PH_VHI: begin
        crc_d   = crc_upd;
        value_d = {rx_byte_i, value_q[7:0]};
        phase_d = PH_VLO;
      end
      PH_VLO: begin
        crc_d   = crc_upd;
        value_d = {value_q[15:8], rx_byte_i};
        phase_d = (func_q == FC_WRITE_COILS[3:0]) ? PH_BCNT : PH_CLO;
      end
      PH_BCNT: begin
        crc_d  = crc_upd;
        decl_d = FILL_W'(rx_byte_i);
        fill_d = '0;
        if (rx_byte_i > 8'(DATA_MAX)) begin
          phase_d = PH_ADDR;
        end else if (rx_byte_i == 8'd0) begin
          phase_d = PH_CLO;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        crc_d    = crc_upd;
        store_we = 1'b1;
        fill_d   = fill_inc;
        if (fill_inc >= decl_q) begin
          phase_d = PH_CLO;
        end
      end
      PH_CLO: begin
        fcrc_lo_d = rx_byte_i;
        phase_d   = PH_CHI;
      end
      PH_CHI: begin
        phase_d  = PH_ADDR;
        fbytes_d = '0;
        hit_o    = ({rx_byte_i, fcrc_lo_q} == crc_q);
      end
      default: begin
        phase_d  = PH_ADDR;
        fbytes_d = '0;
      end
    endcase
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_ADDR;
      fbytes_q  <= '0;
      crc_q     <= CRC_INIT;
      func_q    <= '0;
      addr_q    <= '0;
      value_q   <= '0;
      decl_q    <= '0;
      fill_q    <= '0;
      fcrc_lo_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      fbytes_q  <= fbytes_d;
      crc_q     <= crc_d;
      func_q    <= func_d;
      addr_q    <= addr_d;
      value_q   <= value_d;
      decl_q    <= decl_d;
      fill_q    <= fill_d;
      fcrc_lo_q <= fcrc_lo_d;
    end
  end

  // Data byte store, one entry per visible byte up to DATA_MAX
  for (genvar k = 0; k < STORE_D; k++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (step_i && store_we && fill_q == FILL_W'(k)) begin
        store_q[k] <= rx_byte_i;
      end
    end
  end

  // Mask bytes at or beyond the fill count
  for (genvar k = 0; k < COIL_BYTES; k++) begin : g_coil
    if (k < STORE_D) begin : g_on
      assign coil_byte[k] = (fill_q > FILL_W'(k)) ? store_q[k] : 8'h00;
    end else begin : g_off
      assign coil_byte[k] = 8'h00;
    end
  end

  assign res_o.func_code      = func_q;
  assign res_o.first_address  = addr_q;
  assign res_o.count_or_value = value_q;
  assign res_o.data_length    = 4'(fill_q);
  assign res_o.coil_bits_low  = {coil_byte[7], coil_byte[6], coil_byte[5], coil_byte[4],
                                 coil_byte[3], coil_byte[2], coil_byte[1], coil_byte[0]};
  assign res_o.coil_bits_high = {coil_byte[9], coil_byte[8]};

endmodule

// ===== sv/modbus_rtu_request_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_request_receiver_unit: RTU request receiver, slave side
// A request enters the result register as its last CRC byte steps from the
// input register into the parser. Throughput: one byte per cycle while the
// result register is free or drained, set by the CRC and phase update.
// Reset: asynchronous, active low; parser idles hunting for an address,
// device id 1, gap limit 100 ms.
// ----------------------------------------------------------------------------
module modbus_rtu_request_receiver_unit #(
  parameter int FRAME_LIMIT = mrtu_pkg::FRAME_LIMIT_DEF,
  parameter int DATA_MAX    = mrtu_pkg::DATA_MAX_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write port
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [7:0]   cfg_data_i,
  // Byte stream in
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [15:0]  s_axis_tdata_i,   // rx_byte[7:0], gap_ms[15:8]
  // Request stream out
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [119:0] m_axis_tdata_o    // func_code[3:0], first_address[19:4],
                                         // count_or_value[35:20],
                                         // data_length[39:36],
                                         // coil_bits_low[103:40],
                                         // coil_bits_high[119:104]
);
  import mrtu_pkg::*;

  cfg_t       cfg_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic [7:0] in_gap_q;
  logic       res_valid_q;
  res_t       res_q;
  logic       advance;
  logic       step;
  logic       hit;
  res_t       res;

  // Move forward whenever the result register is free or drained
  assign advance         = !res_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && advance;
  assign s_axis_tready_o = advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_id    <= DEVICE_ID_RST;
      cfg_q.gap_limit_ms <= GAP_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEVICE_ID: cfg_q.device_id    <= cfg_data_i[6:0];
        REG_GAP_LIMIT: cfg_q.gap_limit_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i[7:0];
      in_gap_q  <= s_axis_tdata_i[15:8];
    end
  end

  mrtu_parser #(
    .FRAME_LIMIT (FRAME_LIMIT),
    .DATA_MAX    (DATA_MAX)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .step_i    (step),
    .rx_byte_i (in_byte_q),
    .gap_ms_i  (in_gap_q),
    .hit_o     (hit),
    .res_o     (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= step && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && hit) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tdata_o  = res_q;

endmodule

// ===== sv/mrtu_checker.sv =====
// ----------------------------------------------------------------------------
// mrtu_checker: port-level checks for the request receiver
// Watches the stream ports and flags handshake and decode slips.
// ----------------------------------------------------------------------------
module mrtu_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [119:0] m_axis_tdata_o
);
  import mrtu_pkg::*;

  // Hold a stalled request steady
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled request changed");

  // Accept bytes whenever no request waits
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

  // Emit only supported function codes
  a_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[3:0] == FC_READ_COILS[3:0] ||
                         m_axis_tdata_o[3:0] == FC_READ_HOLD[3:0] ||
                         m_axis_tdata_o[3:0] == FC_WRITE_COIL[3:0] ||
                         m_axis_tdata_o[3:0] == FC_WRITE_REG[3:0] ||
                         m_axis_tdata_o[3:0] == FC_WRITE_COILS[3:0]))
    else $error("bad function code");

  // Keep the data length within the visible bytes
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[39:36] <= 4'd10)
    else $error("data length out of range");

  // Raise a request only after its closing byte passed the input register and parser
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("request without a closing byte");

endmodule

bind modbus_rtu_request_receiver_unit mrtu_checker u_mrtu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the RTU request receiver
// Streams serial bytes with their idle times into the receiver, predicts the
// decoded requests in a cycle-free model of the parser, and checks every
// request that leaves the block against that prediction, field by field.
// Directed frames cover each function code, the extremes of the fields and
// the drop and restart cases; random well-formed frames, broken frames and
// noise follow under several register settings and back-pressure mixes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mrtu_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 330;
  localparam int CHUNKS        = 6;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic         cfg_index = REG_DEVICE_ID;
  logic [7:0]   cfg_data = 8'h00;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [15:0]  s_tdata = 16'h0000;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;

  // Idle percentages of the byte source and the request sink
  int src_idle_pct = 25;
  int dst_idle_pct = 50;

  int failures = 0;
  int frame_items = 0;
  int stall_cycles = 0;

  // Parser model: register copies and frame state
  logic [6:0]  p_dev_id;
  logic [7:0]  p_gap_lim;
  logic [3:0]  p_phase;
  int          p_nbytes;
  logic [15:0] p_crc;
  logic [7:0]  p_func;
  logic [15:0] p_addr;
  logic [15:0] p_value;
  logic [7:0]  p_declared;
  int          p_fill;
  logic [7:0]  p_data [DATA_MAX_DEF];
  logic [15:0] p_frame_crc;

  res_t expected_requests [$];
  res_t got_req;
  res_t want_req;

  // Bytes of the frame being sent
  logic [7:0] frame_q [$];

  modbus_rtu_request_receiver_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),    // rx_byte[7:0], gap_ms[15:8]
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)     // func_code[3:0], first_address[19:4],
                                   // count_or_value[35:20], data_length[39:36],
                                   // coil_bits_low[103:40], coil_bits_high[119:104]
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // CRC-16, reflected, one data bit per step
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] crc;
    logic        fb;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[0] ^ data[k];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic logic is_known_function(input logic [7:0] fc);
    return fc == FC_READ_COILS || fc == FC_READ_HOLD || fc == FC_WRITE_COIL ||
           fc == FC_WRITE_REG || fc == FC_WRITE_COILS;
  endfunction

  // Advance the parser model by one byte and queue any decoded request
  task automatic predict_byte(input logic [7:0] c, input logic [7:0] gap);
    res_t req;
    int   len;
    if (gap > p_gap_lim) begin
      p_phase  = PH_ADDR;
      p_nbytes = 0;
    end
    if (p_phase != PH_ADDR) begin
      p_nbytes++;
      if (p_nbytes >= FRAME_LIMIT_DEF) begin
        p_phase  = PH_ADDR;
        p_nbytes = 0;
      end
    end
    case (p_phase)
      PH_ADDR: begin
        if (c == {1'b0, p_dev_id}) begin
          p_crc       = crc16_update(CRC_INIT, c);
          p_nbytes    = 1;
          p_func      = 8'h00;
          p_addr      = 16'h0000;
          p_value     = 16'h0000;
          p_declared  = 8'h00;
          p_fill      = 0;
          p_frame_crc = 16'h0000;
          p_phase     = PH_FUNC;
        end
      end
      PH_FUNC: begin
        p_crc   = crc16_update(p_crc, c);
        p_func  = c;
        p_phase = is_known_function(c) ? PH_AHI : PH_ADDR;
      end
      PH_AHI: begin
        p_crc        = crc16_update(p_crc, c);
        p_addr[15:8] = c;
        p_phase      = PH_ALO;
      end
      PH_ALO: begin
        p_crc       = crc16_update(p_crc, c);
        p_addr[7:0] = c;
        p_phase     = PH_VHI;
      end
      PH_VHI: begin
        p_crc         = crc16_update(p_crc, c);
        p_value[15:8] = c;
        p_phase       = PH_VLO;
      end
      PH_VLO: begin
        p_crc        = crc16_update(p_crc, c);
        p_value[7:0] = c;
        p_phase      = (p_func == FC_WRITE_COILS) ? PH_BCNT : PH_CLO;
      end
      PH_BCNT: begin
        p_crc      = crc16_update(p_crc, c);
        p_declared = c;
        p_fill     = 0;
        if (c > DATA_MAX_DEF) begin
          p_phase = PH_ADDR;
        end else if (c == 8'h00) begin
          p_phase = PH_CLO;
        end else begin
          p_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        p_crc = crc16_update(p_crc, c);
        if (p_fill < DATA_MAX_DEF) begin
          p_data[p_fill] = c;
        end
        p_fill++;
        if (p_fill >= p_declared) begin
          p_phase = PH_CLO;
        end
      end
      PH_CLO: begin
        p_frame_crc = {8'h00, c};
        p_phase     = PH_CHI;
      end
      PH_CHI: begin
        p_frame_crc[15:8] = c;
        p_phase           = PH_ADDR;
        p_nbytes          = 0;
        if (p_frame_crc == p_crc) begin
          req = '0;
          len = (p_func == FC_WRITE_COILS) ? p_fill : 0;
          for (int k = 0; k < len && k < DATA_MAX_DEF && k < COIL_BYTES; k++) begin
            if (k < 8) begin
              req.coil_bits_low[8*k +: 8] = p_data[k];
            end else begin
              req.coil_bits_high[8*(k-8) +: 8] = p_data[k];
            end
          end
          req.func_code      = p_func[3:0];
          req.first_address  = p_addr;
          req.count_or_value = p_value;
          req.data_length    = len[3:0];
          expected_requests.push_back(req);
        end
      end
      default: begin
        p_phase  = PH_ADDR;
        p_nbytes = 0;
      end
    endcase
  endtask

  task automatic note_failure(input string what, input res_t want, input res_t got);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%0t %s: expected fc=%0d addr=%h val=%h len=%0d coils=%h_%h",
               $realtime, what, want.func_code, want.first_address,
               want.count_or_value, want.data_length, want.coil_bits_high,
               want.coil_bits_low);
      $display("%0t %s:      got fc=%0d addr=%h val=%h len=%0d coils=%h_%h",
               $realtime, what, got.func_code, got.first_address,
               got.count_or_value, got.data_length, got.coil_bits_high,
               got.coil_bits_low);
    end
  endtask

  // Check requests, track register writes, predict accepted bytes, drive the sink
  always @(posedge clk) begin
    if (rst_n) begin
      if (m_tvalid && m_tready) begin
        got_req = m_tdata;
        if (expected_requests.size() == 0) begin
          note_failure("request with none pending", '0, got_req);
        end else begin
          want_req = expected_requests.pop_front();
          if (got_req.func_code      !== want_req.func_code      ||
              got_req.first_address  !== want_req.first_address  ||
              got_req.count_or_value !== want_req.count_or_value ||
              got_req.data_length    !== want_req.data_length    ||
              got_req.coil_bits_low  !== want_req.coil_bits_low  ||
              got_req.coil_bits_high !== want_req.coil_bits_high) begin
            note_failure("request mismatch", want_req, got_req);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_DEVICE_ID) begin
          p_dev_id = cfg_data[6:0];
        end else begin
          p_gap_lim = cfg_data;
        end
      end
      if (s_tvalid && s_tready) begin
        predict_byte(s_tdata[7:0], s_tdata[15:8]);
      end
    end
    m_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one byte, idling first at random, and hold it until accepted
  task automatic send_item(input logic [7:0] rx_byte, input logic [7:0] gap_ms);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {gap_ms, rx_byte};
    do @(posedge clk); while (!s_tready);
  endtask

  // Send the first n bytes of the frame; later bytes come within the gap limit
  task automatic send_frame(input logic [7:0] first_gap, input int n);
    for (int i = 0; i < n && i < frame_q.size(); i++) begin
      send_item(frame_q[i], (i == 0) ? first_gap : 8'($urandom_range(int'(p_gap_lim))));
      frame_items++;
    end
  endtask

  // Idle time that is just enough, or more, to reset the parser; 8'hFF if the limit is 8'hFF
  function automatic logic [7:0] restart_gap();
    if (p_gap_lim == 8'hFF) begin
      return 8'hFF;
    end
    return 8'($urandom_range(255, int'(p_gap_lim) + 1));
  endfunction

  function automatic logic [7:0] pick_function();
    case ($urandom_range(4))
      0: return FC_READ_COILS;
      1: return FC_READ_HOLD;
      2: return FC_WRITE_COIL;
      3: return FC_WRITE_REG;
      default: return FC_WRITE_COILS;
    endcase
  endfunction

  // Build a request for the current device id; fill < 0 means random data
  task automatic build_request(input logic [7:0] fc, input logic [15:0] addr,
                               input logic [15:0] value, input int n_data,
                               input int fill);
    logic [15:0] crc;
    frame_q.delete();
    frame_q.push_back({1'b0, p_dev_id});
    frame_q.push_back(fc);
    frame_q.push_back(addr[15:8]);
    frame_q.push_back(addr[7:0]);
    frame_q.push_back(value[15:8]);
    frame_q.push_back(value[7:0]);
    if (fc == FC_WRITE_COILS) begin
      frame_q.push_back(8'(n_data));
      for (int k = 0; k < n_data && k < DATA_MAX_DEF + 2; k++) begin
        frame_q.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
      end
    end
    crc = CRC_INIT;
    foreach (frame_q[i]) begin
      crc = crc16_update(crc, frame_q[i]);
    end
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
  endtask

  // Wait until every pending request is out and the parser has gone quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_requests.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic set_config(input logic [7:0] id_word, input logic [7:0] gap_limit);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEVICE_ID;
    cfg_data  <= id_word;
    @(posedge clk);
    cfg_index <= REG_GAP_LIMIT;
    cfg_data  <= gap_limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Requests under the reset register values, address and value extremes
  task automatic test_reset_defaults();
    build_request(FC_READ_HOLD, 16'h0000, 16'h0000, 0, 0);
    send_frame(restart_gap(), frame_q.size());
    build_request(FC_READ_COILS, 16'hFFFF, 16'hFFFF, 0, 0);
    send_frame(restart_gap(), frame_q.size());
  endtask

  // Write function codes, and write-coils byte counts from zero to the maximum
  task automatic test_function_codes();
    build_request(FC_WRITE_COIL, 16'hA5A5, 16'hFF00, 0, 0);
    send_frame(restart_gap(), frame_q.size());
    build_request(FC_WRITE_REG, 16'h5A5A, 16'h1234, 0, 0);
    send_frame(restart_gap(), frame_q.size());
    build_request(FC_WRITE_COILS, 16'h0010, 16'h0000, 0, 0);
    send_frame(restart_gap(), frame_q.size());
    build_request(FC_WRITE_COILS, 16'h0020, 16'h0008, 1, -1);
    send_frame(restart_gap(), frame_q.size());
    build_request(FC_WRITE_COILS, 16'h0030, 16'h0040, 8, -1);
    send_frame(restart_gap(), frame_q.size());
    build_request(FC_WRITE_COILS, 16'hFFFF, 16'hFFFF, DATA_MAX_DEF, 8'hFF);
    send_frame(restart_gap(), frame_q.size());
  endtask

  // Frames that must yield nothing, and restarts right after a drop
  task automatic test_dropped_frames();
    // stray bytes that do not match the device id
    send_item(8'h81, 8'hFF);
    send_item(8'hFF, 8'h00);
    send_item(8'h00, 8'h7F);
    // unknown function codes
    build_request(8'h00, 16'h0001, 16'h0001, 0, 0);
    send_frame(restart_gap(), frame_q.size());
    build_request(8'hFF, 16'h0101, 16'h0101, 0, 0);
    send_frame(restart_gap(), frame_q.size());
    // byte count above the data limit
    build_request(FC_WRITE_COILS, 16'h0000, 16'h0000, DATA_MAX_DEF + 1, -1);
    send_frame(restart_gap(), frame_q.size());
    build_request(FC_WRITE_COILS, 16'h0000, 16'h0000, 255, -1);
    send_frame(restart_gap(), frame_q.size());
    // bad CRC high byte
    build_request(FC_READ_HOLD, 16'h0100, 16'h0002, 0, 0);
    frame_q[frame_q.size() - 1] ^= 8'h80;
    send_frame(restart_gap(), frame_q.size());
    // bad code dropped, next address byte restarts without a long idle gap
    build_request(8'h02, 16'h0000, 16'h0000, 0, 0);
    send_frame(restart_gap(), 2);
    build_request(FC_WRITE_REG, 16'h0007, 16'hBEEF, 0, 0);
    send_frame(8'($urandom_range(int'(p_gap_lim))), frame_q.size());
  endtask

  // Gaps at the limit keep a frame, gaps above it restart the parser
  task automatic test_idle_gap();
    build_request(FC_READ_HOLD, 16'h1111, 16'h0003, 0, 0);
    foreach (frame_q[i]) begin
      send_item(frame_q[i], (i == 0) ? restart_gap() : p_gap_lim);
    end
    // partial frame, then a new frame whose address byte follows a long gap
    build_request(FC_WRITE_COILS, 16'h2222, 16'h0010, 2, -1);
    send_frame(restart_gap(), 4);
    build_request(FC_READ_COILS, 16'h3333, 16'h0010, 0, 0);
    send_frame(restart_gap(), frame_q.size());
    // long gap in the middle of a frame
    build_request(FC_WRITE_REG, 16'h4444, 16'h5555, 0, 0);
    send_frame(restart_gap(), 4);
    send_item(frame_q[4], restart_gap());
    for (int i = 5; i < frame_q.size(); i++) begin
      send_item(frame_q[i], 8'($urandom_range(int'(p_gap_lim))));
    end
  endtask

  // Register extremes: id 0 with zero gap limit, id 127 with no gap reset
  task automatic test_register_extremes();
    set_config(8'h00, 8'h00);
    build_request(FC_WRITE_COILS, 16'h0000, 16'hFFFF, 3, -1);
    send_frame(restart_gap(), frame_q.size());
    build_request(FC_READ_HOLD, 16'h8000, 16'h0001, 0, 0);
    send_frame(8'hFF, frame_q.size());
    set_config(8'hFF, 8'hFF);
    build_request(FC_WRITE_REG, 16'h7F7F, 16'h0000, 0, 0);
    send_frame(8'hFF, frame_q.size());
    build_request(FC_WRITE_COILS, 16'h00FF, 16'h0050, DATA_MAX_DEF, 8'h00);
    send_frame(8'hFF, frame_q.size());
    set_config({1'b0, DEVICE_ID_RST}, GAP_LIMIT_RST);
  endtask

  // Mostly well-formed frames with random content, plus broken frames and noise
  task automatic test_random_traffic();
    int          target;
    int          pick;
    logic [7:0]  fc;
    logic [7:0]  id_word;
    logic [7:0]  gap_limit;
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      case (chunk / 2)
        0: begin
          src_idle_pct = 25;
          dst_idle_pct = 50;
        end
        1: begin
          src_idle_pct = 50;
          dst_idle_pct = 25;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      case (chunk)
        1: begin
          id_word   = 8'h7F;
          gap_limit = 8'h00;
        end
        2: begin
          id_word   = 8'h00;
          gap_limit = 8'hFF;
        end
        4: begin
          id_word   = {1'b0, DEVICE_ID_RST};
          gap_limit = GAP_LIMIT_RST;
        end
        default: begin
          id_word   = 8'($urandom_range(255));
          gap_limit = 8'($urandom_range(255));
        end
      endcase
      set_config(id_word, gap_limit);
      target = frame_items + RANDOM_ITEMS / CHUNKS;
      while (frame_items < target) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          build_request(pick_function(), 16'($urandom), 16'($urandom),
                        $urandom_range(DATA_MAX_DEF), -1);
          send_frame(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : restart_gap(),
                     frame_q.size());
        end else if (pick < 85) begin
          case ($urandom_range(3))
            0: begin
              // flip one bit anywhere in the frame
              build_request(pick_function(), 16'($urandom), 16'($urandom),
                            $urandom_range(DATA_MAX_DEF), -1);
              pick = $urandom_range(frame_q.size() - 1);
              frame_q[pick] ^= 8'(1 << $urandom_range(7));
              send_frame(restart_gap(), frame_q.size());
            end
            1: begin
              do fc = 8'($urandom_range(255)); while (is_known_function(fc));
              build_request(fc, 16'($urandom), 16'($urandom), 0, 0);
              send_frame(restart_gap(), frame_q.size());
            end
            2: begin
              build_request(FC_WRITE_COILS, 16'($urandom), 16'($urandom),
                            $urandom_range(255, DATA_MAX_DEF + 1), -1);
              send_frame(restart_gap(), frame_q.size());
            end
            default: begin
              build_request(pick_function(), 16'($urandom), 16'($urandom),
                            $urandom_range(DATA_MAX_DEF), -1);
              send_frame(restart_gap(), $urandom_range(frame_q.size() - 1, 1));
            end
          endcase
        end else begin
          repeat ($urandom_range(4, 1)) begin
            send_item(8'($urandom_range(255)), 8'($urandom_range(255)));
          end
        end
      end
    end
  endtask

  initial begin
    p_dev_id    = DEVICE_ID_RST;
    p_gap_lim   = GAP_LIMIT_RST;
    p_phase     = PH_ADDR;
    p_nbytes    = 0;
    p_crc       = CRC_INIT;
    p_func      = 8'h00;
    p_addr      = 16'h0000;
    p_value     = 16'h0000;
    p_declared  = 8'h00;
    p_fill      = 0;
    p_frame_crc = 16'h0000;
    foreach (p_data[i]) begin
      p_data[i] = 8'h00;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_function_codes();
    test_dropped_frames();
    test_idle_gap();
    test_register_extremes();
    test_random_traffic();

    settle();
    if (failures == 0 && expected_requests.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
